@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked only while out of reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/aabbat_pkg.sv @@
// ----------------------------------------------------------------------------
// AABB affine transform package
// Shared constants, register indexes and pipeline control types.
// ----------------------------------------------------------------------------
package aabbat_pkg;

  // Default coordinate and coefficient formats.
  localparam int COORD_WIDTH_DEF    = 16;
  localparam int COEF_FRAC_BITS_DEF = 12;

  // Packed matrix row: three coefficients and one translation, 16 bits each.
  localparam int COEF_W    = 16;
  localparam int NUM_AXES  = 3;
  localparam int ROW_W     = 64;
  localparam int TRANS_LSB = 48;
  localparam int CFG_IDX_W = 2;

  // Reset rows form the identity at the default fraction width.
  localparam logic [ROW_W-1:0] ROW_X_RST = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW_Y_RST = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RST = 64'h0000_1000_0000_0000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X = 2'd0,
    REG_ROW_Y = 2'd1,
    REG_ROW_Z = 2'd2
  } aabbat_reg_t;

  // Load enables of the four pipeline register stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } aabbat_adv_t;

endpackage

@@ src/aabbat_if.sv @@
// ----------------------------------------------------------------------------
// AABB affine transform channel interfaces
// Box channel (valid, ready, two corners) and configuration write channel.
// ----------------------------------------------------------------------------
interface aabbat_box_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] lo_x;
  logic signed [COORD_WIDTH-1:0] lo_y;
  logic signed [COORD_WIDTH-1:0] lo_z;
  logic signed [COORD_WIDTH-1:0] hi_x;
  logic signed [COORD_WIDTH-1:0] hi_y;
  logic signed [COORD_WIDTH-1:0] hi_z;

  modport source (output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, input ready);
  modport sink   (input valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, output ready);
endinterface

interface aabbat_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/aabbat_lane.sv @@
// ----------------------------------------------------------------------------
// AABB affine transform lane
// Datapath for one output axis: products, min/max select, sum, round/saturate.
// ----------------------------------------------------------------------------
module aabbat_lane #(
  parameter int COORD_WIDTH    = 16,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                                               clk,
  input  aabbat_pkg::aabbat_adv_t                            adv,
  input  logic [aabbat_pkg::ROW_W-1:0]                       row,
  input  logic [aabbat_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]   lo,
  input  logic [aabbat_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]   hi,
  output logic signed [COORD_WIDTH-1:0]                      res_lo,
  output logic signed [COORD_WIDTH-1:0]                      res_hi
);
  import aabbat_pkg::*;

  localparam int PW    = COEF_W + COORD_WIDTH;
  localparam int ACC_W = COEF_W + COORD_WIDTH + COEF_FRAC_BITS + 3;
  localparam int SH_W  = ACC_W - COEF_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [SH_W-1:0]  SAT_MAX = SH_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SH_W-1:0]  SAT_MIN = -SAT_MAX - SH_W'(1);

  logic signed [COEF_W-1:0]      coef     [NUM_AXES];
  logic signed [COEF_W-1:0]      trans;
  logic signed [PW-1:0]          p_r      [NUM_AXES];
  logic signed [PW-1:0]          q_r      [NUM_AXES];
  logic signed [PW-1:0]          mn_r     [NUM_AXES];
  logic signed [PW-1:0]          mx_r     [NUM_AXES];
  logic signed [COEF_W-1:0]      trans1_r;
  logic signed [COEF_W-1:0]      trans2_r;
  logic signed [ACC_W-1:0]       lo_acc_r;
  logic signed [ACC_W-1:0]       hi_acc_r;
  logic signed [SH_W-1:0]        lo_sh;
  logic signed [SH_W-1:0]        hi_sh;

  // Clamp a rounded value to the signed coordinate range.
  function automatic logic signed [COORD_WIDTH-1:0] saturate(input logic signed [SH_W-1:0] v);
    logic signed [SH_W-1:0] c;
    if (v > SAT_MAX) begin
      c = SAT_MAX;
    end else if (v < SAT_MIN) begin
      c = SAT_MIN;
    end else begin
      c = v;
    end
    return c[COORD_WIDTH-1:0];
  endfunction

  // Unpack the matrix row.
  always_comb begin
    for (int j = 0; j < NUM_AXES; j++) begin
      coef[j] = $signed(row[j*COEF_W +: COEF_W]);
    end
    trans = $signed(row[TRANS_LSB +: COEF_W]);
  end

  // Stage 1: coefficient times both corner coordinates.
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        p_r[j] <= PW'(coef[j]) * PW'($signed(lo[j]));
        q_r[j] <= PW'(coef[j]) * PW'($signed(hi[j]));
      end
      trans1_r <= trans;
    end
  end

  // Stage 2: pick the smaller and larger product of each term.
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        mn_r[j] <= (p_r[j] < q_r[j]) ? p_r[j] : q_r[j];
        mx_r[j] <= (p_r[j] < q_r[j]) ? q_r[j] : p_r[j];
      end
      trans2_r <= trans1_r;
    end
  end

  // Stage 3: scaled translation plus the three terms plus the rounding half.
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      lo_acc_r <= (ACC_W'(trans2_r) <<< COEF_FRAC_BITS) + ACC_W'(mn_r[0])
                  + ACC_W'(mn_r[1]) + ACC_W'(mn_r[2]) + RND;
      hi_acc_r <= (ACC_W'(trans2_r) <<< COEF_FRAC_BITS) + ACC_W'(mx_r[0])
                  + ACC_W'(mx_r[1]) + ACC_W'(mx_r[2]) + RND;
    end
  end

  // Floor shift back to the coordinate format.
  assign lo_sh = SH_W'(lo_acc_r >>> COEF_FRAC_BITS);
  assign hi_sh = SH_W'(hi_acc_r >>> COEF_FRAC_BITS);

  // Stage 4: saturated result into the output register.
  always_ff @(posedge clk) begin
    if (adv.s4) begin
      res_lo <= saturate(lo_sh);
      res_hi <= saturate(hi_sh);
    end
  end

endmodule

@@ src/aabb_affine_transform_unit.sv @@
// An accepted box passes through the product, min/max, sum and saturate stages to the output.
// Throughput: one box per cycle; each stage holds one box and stalls only on output backpressure.
// Reset clears all stage valid bits and loads the identity matrix rows.
// ----------------------------------------------------------------------------
// AABB affine transform unit
// Transforms an axis-aligned box by a 3x4 fixed-point matrix, per-axis min/max.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aabb_affine_transform_unit #(
  parameter int COORD_WIDTH    = aabbat_pkg::COORD_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = aabbat_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  aabbat_box_if.sink          in_box,
  aabbat_box_if.source        out_box,
  aabbat_cfg_if.sink          cfg_wr
);
  import aabbat_pkg::*;

  localparam int STAGES = 4;

  logic [ROW_W-1:0]                      row_r   [NUM_AXES];
  logic [STAGES-1:0]                     v_r;
  logic [STAGES-1:0]                     rdy;
  aabbat_adv_t                           adv;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  lo_vec;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  hi_vec;
  logic signed [COORD_WIDTH-1:0]         res_lo  [NUM_AXES];
  logic signed [COORD_WIDTH-1:0]         res_hi  [NUM_AXES];

  // Configuration writes are always taken.
  assign cfg_wr.ready = 1'b1;

  // Matrix row registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= ROW_X_RST;
      row_r[1] <= ROW_Y_RST;
      row_r[2] <= ROW_Z_RST;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      unique case (cfg_wr.index)
        REG_ROW_X: row_r[0] <= cfg_wr.data;
        REG_ROW_Y: row_r[1] <= cfg_wr.data;
        REG_ROW_Z: row_r[2] <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // A stage can load when it is empty or its contents move on.
  always_comb begin
    rdy[STAGES-1] = !v_r[STAGES-1] || out_box.ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign adv.s1 = rdy[0];
  assign adv.s2 = rdy[1];
  assign adv.s3 = rdy[2];
  assign adv.s4 = rdy[3];

  assign in_box.ready = rdy[0];

  // Valid bits travel with the data through the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_box.valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Corner coordinates as vectors for the lanes.
  assign lo_vec = {in_box.lo_z, in_box.lo_y, in_box.lo_x};
  assign hi_vec = {in_box.hi_z, in_box.hi_y, in_box.hi_x};

  // One datapath lane per output axis.
  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    aabbat_lane #(
      .COORD_WIDTH    (COORD_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .adv    (adv),
      .row    (row_r[i]),
      .lo     (lo_vec),
      .hi     (hi_vec),
      .res_lo (res_lo[i]),
      .res_hi (res_hi[i])
    );
  end

  // Result request.
  assign out_box.valid = v_r[STAGES-1];
  assign out_box.lo_x  = res_lo[0];
  assign out_box.lo_y  = res_lo[1];
  assign out_box.lo_z  = res_lo[2];
  assign out_box.hi_x  = res_hi[0];
  assign out_box.hi_y  = res_hi[1];
  assign out_box.hi_z  = res_hi[2];

  // An accepted request occupies the first stage next cycle.
  `ASSERT_NEXT(a_in_enters, clk, rst_n, in_box.valid && in_box.ready, v_r[0])
  // A request in stage three that may advance reaches the output register.
  `ASSERT_NEXT(a_reach_out, clk, rst_n, v_r[2] && rdy[3], v_r[3])
  // A write of the first row lands in its register.
  `ASSERT_NEXT(a_row_x_wr, clk, rst_n, cfg_wr.valid && cfg_wr.ready && (cfg_wr.index == REG_ROW_X), row_r[0] == $past(cfg_wr.data))

endmodule

@@ tb/tb_aabb_affine_transform_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AABB affine transform unit testbench
// Sends boxes through the unit under several matrix settings and compares
// every returned box with a local fixed-point min/max transform, with random
// idling on both the request and the result side.
// ----------------------------------------------------------------------------
module tb_aabb_affine_transform_unit;
  import aabbat_pkg::*;

  localparam int CW          = COORD_WIDTH_DEF;
  localparam int FRAC        = COEF_FRAC_BITS_DEF;
  localparam int LATENCY     = 4;
  localparam int MAX_REPORTS = 40;
  localparam int PER_SETTING = 47;
  localparam int SETTINGS_N  = 6;
  localparam longint TIMEOUT_NS = 6_000_000;

  // Index outside the register map; the unit must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  // One box: index 0, 1, 2 of each corner is x, y, z.
  typedef struct packed {
    logic [NUM_AXES-1:0][CW-1:0] lo;
    logic [NUM_AXES-1:0][CW-1:0] hi;
  } box_t;

  logic clk;
  logic rst_n;

  aabbat_box_if #(.COORD_WIDTH(CW)) in_if ();
  aabbat_box_if #(.COORD_WIDTH(CW)) out_if ();
  aabbat_cfg_if cfg_if ();

  aabb_affine_transform_unit #(
    .COORD_WIDTH   (CW),
    .COEF_FRAC_BITS(FRAC)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_box (in_if),
    .out_box(out_if),
    .cfg_wr (cfg_if)
  );

  // Local copy of the matrix rows and the queue of boxes still owed.
  logic [ROW_W-1:0] matrix_rows [NUM_AXES];
  box_t             expected_boxes [$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int boxes_sent;
  int boxes_checked;
  int row_writes;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Safety net against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d boxes outstanding", $time, expected_boxes.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Rounds a sum with FRAC + 8 fraction bits to Q8.8, half toward plus
  // infinity, then clamps it to the coordinate range.
  function automatic logic [CW-1:0] round_clamp(longint acc);
    longint r;
    r = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[CW-1:0];
  endfunction

  // Per output axis: translation plus the smaller or larger of coef*lo and
  // coef*hi for every input axis.
  function automatic box_t transform_box(box_t b);
    box_t   r;
    longint t, c, p, q, amin, amax;
    for (int i = 0; i < NUM_AXES; i++) begin
      t = $signed(matrix_rows[i][TRANS_LSB +: COEF_W]);
      amin = t * (longint'(1) <<< FRAC);
      amax = amin;
      for (int j = 0; j < NUM_AXES; j++) begin
        c = $signed(matrix_rows[i][j*COEF_W +: COEF_W]);
        p = c * longint'($signed(b.lo[j]));
        q = c * longint'($signed(b.hi[j]));
        amin += (p < q) ? p : q;
        amax += (p < q) ? q : p;
      end
      r.lo[i] = round_clamp(amin);
      r.hi[i] = round_clamp(amax);
    end
    return r;
  endfunction

  function automatic box_t make_box(int lx, int ly, int lz, int hx, int hy, int hz);
    box_t b;
    b.lo[0] = lx[CW-1:0];
    b.lo[1] = ly[CW-1:0];
    b.lo[2] = lz[CW-1:0];
    b.hi[0] = hx[CW-1:0];
    b.hi[1] = hy[CW-1:0];
    b.hi[2] = hz[CW-1:0];
    return b;
  endfunction

  // Random matrix row: raw bits, extreme words, moderate gains, or a signed
  // unit on one axis.
  function automatic logic [ROW_W-1:0] random_row();
    logic [ROW_W-1:0] r;
    logic [15:0]      pick [4];
    pick = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000};
    r = '0;
    case ($urandom_range(4))
      0: r = {$urandom, $urandom};
      1: begin
        for (int k = 0; k < 4; k++) r[k*COEF_W +: COEF_W] = pick[$urandom_range(3)];
      end
      2: begin
        for (int k = 0; k < NUM_AXES; k++)
          r[k*COEF_W +: COEF_W] = 16'($urandom_range(16384)) - 16'd8192;
        r[TRANS_LSB +: COEF_W] = 16'($urandom);
      end
      3: begin
        r[$urandom_range(2)*COEF_W +: COEF_W] = $urandom_range(1) ? 16'h1000 : 16'hF000;
        r[TRANS_LSB +: COEF_W] = 16'($urandom_range(4095)) - 16'd2048;
      end
      default: r = {$urandom, $urandom};
    endcase
    return r;
  endfunction

  // Random box: raw, ordered, inverted, small, or built from extreme values.
  function automatic box_t random_box();
    box_t        b;
    logic [15:0] tmp;
    int          kind;
    int          base;
    int          ext [4];
    ext = '{-32768, 32767, 0, -1};
    kind = $urandom_range(5);
    for (int a = 0; a < NUM_AXES; a++) begin
      b.lo[a] = 16'($urandom);
      b.hi[a] = 16'($urandom);
      case (kind)
        1, 2: begin
          // Ordered for kind 1, inverted for kind 2.
          if (($signed(b.lo[a]) > $signed(b.hi[a])) == (kind == 1)) begin
            tmp = b.lo[a];
            b.lo[a] = b.hi[a];
            b.hi[a] = tmp;
          end
        end
        3: begin
          base = int'($urandom_range(4095)) - 2048;
          b.lo[a] = base[CW-1:0];
          b.hi[a] = 16'(base + int'($urandom_range(1023)));
        end
        4: begin
          b.lo[a] = ext[$urandom_range(3)][CW-1:0];
          b.hi[a] = ext[$urandom_range(3)][CW-1:0];
        end
        default: ;
      endcase
    end
    return b;
  endfunction

  // Result side backpressure.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Record each accepted box request and each accepted register write.
  always @(posedge clk) begin : track_requests
    box_t b;
    if (rst_n && in_if.valid && in_if.ready) begin
      b.lo = {in_if.lo_z, in_if.lo_y, in_if.lo_x};
      b.hi = {in_if.hi_z, in_if.hi_y, in_if.hi_x};
      expected_boxes.push_back(transform_box(b));
      boxes_sent++;
    end
    if (rst_n && cfg_if.valid && cfg_if.ready) begin
      row_writes++;
      if (cfg_if.index <= REG_ROW_Z) matrix_rows[cfg_if.index] = cfg_if.data;
    end
  end

  task automatic report_field(string corner, int axis, logic [CW-1:0] want,
                              logic [CW-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s[%0d] mismatch, expected %0d, actual %0d", $time, corner, axis,
               $signed(want), $signed(got));
  endtask

  // Compare each returned box with the oldest one owed.
  always @(posedge clk) begin : check_results
    box_t got;
    box_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.lo = {out_if.lo_z, out_if.lo_y, out_if.lo_x};
      got.hi = {out_if.hi_z, out_if.hi_y, out_if.hi_x};
      if (expected_boxes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = expected_boxes.pop_front();
        boxes_checked++;
        for (int a = 0; a < NUM_AXES; a++) begin
          if (got.lo[a] !== want.lo[a]) report_field("lo", a, want.lo[a], got.lo[a]);
          if (got.hi[a] !== want.hi[a]) report_field("hi", a, want.hi[a], got.hi[a]);
        end
      end
    end
  end

  // Send one box request, with random idle cycles in front of it.
  task automatic send_box(box_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.lo_x  <= b.lo[0];
    in_if.lo_y  <= b.lo[1];
    in_if.lo_z  <= b.lo[2];
    in_if.hi_x  <= b.hi[0];
    in_if.hi_y  <= b.hi[1];
    in_if.hi_z  <= b.hi[2];
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every owed box has come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // One register write, after which valid drops and the write channel goes idle.
  task automatic write_row(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_matrix(logic [ROW_W-1:0] rx, logic [ROW_W-1:0] ry,
                             logic [ROW_W-1:0] rz);
    drain();
    write_row(REG_ROW_X, rx);
    write_row(REG_ROW_Y, ry);
    write_row(REG_ROW_Z, rz);
  endtask

  // Reset matrix is the identity: corners, extremes and an inverted box.
  task automatic test_identity();
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
    send_box(make_box(-1, 1, -256, 256, 100, -100));
    send_box(make_box(1234, -4321, 77, 1300, -4000, 80));
  endtask

  // Gains near plus and minus eight with large offsets drive the sums past
  // both ends of the coordinate range.
  task automatic test_saturation();
    load_matrix(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
                64'h0000_0000_8000_7FFF);
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
    send_box(make_box(16, -16, 8, 32, -8, 16));
    send_box(make_box(0, 0, 0, 0, 0, 0));
  endtask

  // Half gains on odd coordinates land exactly on the rounding midpoint.
  task automatic test_rounding();
    load_matrix(64'h0000_0000_0000_0800, 64'h0000_0000_F800_0000,
                64'h8000_0001_0000_0000);
    send_box(make_box(1, 1, 1, 3, 3, 3));
    send_box(make_box(-1, -1, -1, -3, -3, -3));
    send_box(make_box(-5, 7, 2047, 5, -7, 2049));
    send_box(make_box(-32768, 32767, -32768, 32767, -32768, 32767));
  endtask

  // A write to the unmapped index must leave the matrix untouched.
  task automatic test_unmapped_write();
    load_matrix(ROW_X_RST, ROW_Y_RST, ROW_Z_RST);
    write_row(REG_UNMAPPED, {$urandom, $urandom});
    send_box(make_box(-300, 400, -500, 600, -700, 800));
    send_box(make_box(32767, -32768, 0, -32768, 32767, -1));
    drain();
    write_row(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_box(make_box(10, 20, 30, 40, 50, 60));
  endtask

  // Random boxes under a series of matrix settings for one idling pattern.
  task automatic test_random_phase(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int s = 0; s < SETTINGS_N; s++) begin
      load_matrix(random_row(), random_row(), random_row());
      if ($urandom_range(3) == 0) write_row(REG_UNMAPPED, {$urandom, $urandom});
      for (int n = 0; n < PER_SETTING; n++) begin
        // Once per phase the sender holds off until the pipeline is empty.
        if (s == 2 && n == PER_SETTING / 2) drain();
        send_box(random_box());
      end
    end
  endtask

  // Main sequence.
  initial begin
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.lo_x    = '0;
    in_if.lo_y    = '0;
    in_if.lo_z    = '0;
    in_if.hi_x    = '0;
    in_if.hi_y    = '0;
    in_if.hi_z    = '0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = REG_ROW_X;
    cfg_if.data   = '0;
    send_idle_pct = 31;
    recv_idle_pct = 79;
    mismatches    = 0;
    boxes_sent    = 0;
    boxes_checked = 0;
    row_writes    = 0;
    matrix_rows[0] = ROW_X_RST;
    matrix_rows[1] = ROW_Y_RST;
    matrix_rows[2] = ROW_Z_RST;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_identity();
    test_saturation();
    test_rounding();
    test_unmapped_write();

    test_random_phase(31, 79);
    test_random_phase(79, 31);
    test_random_phase(0, 0);

    // Final extremes of every register before the tail.
    load_matrix(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
                64'h8000_7FFF_8000_7FFF);
    send_box(make_box(-32768, 32767, -1, 32767, -32768, 0));
    drain();

    $display("Sent %0d boxes across %0d register writes under three idling patterns.",
             boxes_sent, row_writes);
    $display("Compared %0d returned boxes, %0d field mismatches.", boxes_checked, mismatches);
    if (mismatches == 0 && expected_boxes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
